// ===== hdl/pbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// pbpa_pkg
// shared constants and types of the power-of-two bucket pool allocator
// ----------------------------------------------------------------------------
package pbpa_pkg;

  // pool geometry
  localparam int MIN_EXPONENT = 16;
  localparam int NUM_BUCKETS  = 17;
  localparam int STACK_DEPTH  = 16;
  localparam int RAM_DEPTH    = NUM_BUCKETS * STACK_DEPTH;
  localparam int ADDR_W       = $clog2(RAM_DEPTH);
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W        = $clog2(NUM_BUCKETS);

  // field widths
  localparam int SIZE_W  = 32;
  localparam int WIDTH_W = 33;
  localparam int ID_W    = 32;
  localparam int SEL_W   = 2;

  // exponent and normalize loop
  localparam int EXP_W      = 6;
  localparam int LZ_W       = 5;
  localparam int NORM_STEPS = 5;
  localparam int STEP_W     = 3;
  localparam int SH_W       = 5;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // rounding select codes
  localparam logic [SEL_W-1:0] SEL_REG = 2'd0;
  localparam logic [SEL_W-1:0] SEL_OFF = 2'd1;
  localparam logic [SEL_W-1:0] SEL_ON  = 2'd2;

  // status from the normalize unit
  typedef struct packed {
    logic             done;
    logic [EXP_W-1:0] bitlen;
  } norm_res_t;

endpackage

// ===== hdl/pow2_bucket_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// pow2_bucket_pool_allocator_top
// buffer pool manager with power-of-two size classes and per-bucket id stacks
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid/in_ready, operation, req_size,   | in
//          | rounding_select, res_width, res_id        |
//  result  | out_valid/out_ready, out_res_id, alloc_id,| out
//          | granted_size, reused, needs_new,          |
//          | released, status                          |
//  config  | cfg_wr_en, cfg_wr_data (default_rounding) | in
//
// a request passes these steps from accept to the next accept: accept, 5 shift
// steps, exponent clamp, lookup, ram read (pops only) and handoff to the result
// register
// synchronous reset clears bucket counts and id counters; stack ram is never
// cleared, only entries below a bucket count are read
// in_ready is high only while idle; a stalled result holds the current request at handoff
//
module pow2_bucket_pool_allocator_top import pbpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [SIZE_W-1:0]  req_size,
  input  logic [SEL_W-1:0]   rounding_select,
  input  logic [WIDTH_W-1:0] res_width,
  input  logic [ID_W-1:0]    res_id,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_res_id,
  output logic [ID_W-1:0]    alloc_id,
  output logic [WIDTH_W-1:0] granted_size,
  output logic               reused,
  output logic               needs_new,
  output logic               released,
  output logic               status,
  // configuration
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  logic default_rounding;

  // latched request
  logic               op_r;
  logic [SIZE_W-1:0]  size_r;
  logic [SEL_W-1:0]   sel_r;
  logic [WIDTH_W-1:0] width_r;
  logic [ID_W-1:0]    rid_r;
  logic [EXP_W-1:0]   e_r;

  // pool state
  logic [CNT_W-1:0] counts [NUM_BUCKETS];
  logic [ID_W-1:0]  next_resource_id;
  logic [ID_W-1:0]  next_alloc_id;

  // pending result
  logic [ID_W-1:0]    p_res_id;
  logic [ID_W-1:0]    p_alloc_id;
  logic [WIDTH_W-1:0] p_granted;
  logic               p_reused;
  logic               p_needs_new;
  logic               p_released;
  logic               p_status;

  // normalize unit
  logic              in_acc;
  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W-1:0] norm_value;
  norm_res_t         norm_res;

  // lookup datapath
  logic [EXP_W-1:0]   idx_full;
  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   cnt;
  logic [WIDTH_W-1:0] bsize;
  logic               round_on;
  logic               pooled;
  logic               fit;
  logic               take_pool;
  logic               push_ok;
  logic [WIDTH_W-1:0] rounded4;

  // stack ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ID_W-1:0]   ram_rdata;

  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // zero size counts as one; bit length of size-1 is ceil(log2(size))
  assign size_eff   = (req_size == '0) ? SIZE_W'(1) : req_size;
  assign norm_value = size_eff - SIZE_W'(1);

  pbpa_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .value (norm_value),
    .res   (norm_res)
  );

  always_comb begin
    idx_full = e_r - EXP_W'(MIN_EXPONENT);
    in_range = idx_full < EXP_W'(NUM_BUCKETS);
    idx      = idx_full[IDX_W-1:0];
    cnt      = in_range ? counts[idx] : '0;
    bsize    = WIDTH_W'(1) << e_r;
    unique case (sel_r)
      SEL_OFF: round_on = 1'b0;
      SEL_ON:  round_on = 1'b1;
      default: round_on = default_rounding;
    endcase
    pooled    = round_on || ({1'b0, size_r} == bsize);
    fit       = in_range && (bsize == width_r);
    take_pool = (op_r == OP_ALLOC) && pooled && in_range && (cnt != '0);
    push_ok   = (op_r == OP_FREE) && fit && (cnt < CNT_W'(STACK_DEPTH));
    rounded4  = ({1'b0, size_r} + WIDTH_W'(3)) & ~WIDTH_W'(3);
  end

  // push writes at the count, pop reads just below it
  assign ram_we   = (state == S_LOOK) && push_ok;
  assign ram_addr = ADDR_W'(32'(idx) * STACK_DEPTH
                            + 32'(push_ok ? cnt : cnt - CNT_W'(1)));

  pbpa_ram #(
    .WIDTH (ID_W),
    .DEPTH (RAM_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (rid_r),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      default_rounding <= 1'b0;
      next_resource_id <= '0;
      next_alloc_id    <= '0;
      out_valid        <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        default_rounding <= cfg_wr_data;
      end
      // result register loads on handoff, else empties once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (norm_res.done) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (op_r == OP_ALLOC) begin
            next_alloc_id <= next_alloc_id + 1'b1;
            if (take_pool) begin
              counts[idx] <= cnt - CNT_W'(1);
            end else begin
              next_resource_id <= next_resource_id + 1'b1;
            end
          end else if (push_ok) begin
            counts[idx] <= cnt + CNT_W'(1);
          end
          state <= take_pool ? S_READ : S_DONE;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request latch, exponent clamp and result datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= operation;
      size_r  <= size_eff;
      sel_r   <= rounding_select;
      width_r <= res_width;
      rid_r   <= res_id;
    end
    if (state == S_NORM && norm_res.done) begin
      e_r <= (norm_res.bitlen < EXP_W'(MIN_EXPONENT)) ? EXP_W'(MIN_EXPONENT)
                                                      : norm_res.bitlen;
    end
    if (state == S_LOOK) begin
      if (op_r == OP_ALLOC) begin
        p_res_id    <= next_resource_id + 1'b1;
        p_alloc_id  <= next_alloc_id + 1'b1;
        p_granted   <= pooled ? bsize : rounded4;
        p_reused    <= take_pool;
        p_needs_new <= !take_pool;
        p_released  <= 1'b0;
        p_status    <= 1'b0;
      end else begin
        p_res_id    <= rid_r;
        p_alloc_id  <= '0;
        p_granted   <= '0;
        p_reused    <= 1'b0;
        p_needs_new <= 1'b0;
        p_released  <= !push_ok;
        p_status    <= fit && !push_ok;
      end
    end
    // popped id arrives in the cycle after the read address
    if (state == S_READ) begin
      p_res_id <= ram_rdata;
    end
    if (state == S_DONE && out_free) begin
      out_res_id   <= p_res_id;
      alloc_id     <= p_alloc_id;
      granted_size <= p_granted;
      reused       <= p_reused;
      needs_new    <= p_needs_new;
      released     <= p_released;
      status       <= p_status;
    end
  end

endmodule

// ===== hdl/pbpa_ram.sv =====
// ----------------------------------------------------------------------------
// pbpa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module pbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/pbpa_norm.sv =====
// ----------------------------------------------------------------------------
// pbpa_norm
// iterative bit-length unit: one compare-and-shift step per cycle
// ----------------------------------------------------------------------------
module pbpa_norm import pbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIZE_W-1:0] value,
  output norm_res_t         res
);

  logic [SIZE_W-1:0] x;
  logic [LZ_W-1:0]   lz;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              zero;
  logic [SH_W-1:0]   sh;
  logic              top_clear;

  // shift amount halves each step: 16, 8, 4, 2, 1
  assign sh        = SH_W'(SIZE_W / 2) >> step;
  assign top_clear = (x & ~({SIZE_W{1'b1}} >> sh)) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(NORM_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= value;
      lz   <= '0;
      zero <= (value == '0);
    end else if (busy && top_clear) begin
      x  <= x << sh;
      lz <= lz + LZ_W'(sh);
    end
  end

  assign res.done   = done;
  assign res.bitlen = zero ? '0 : EXP_W'(SIZE_W) - EXP_W'(lz);

endmodule
